@@ design/lr_pkg.sv @@
// lr_pkg: shared types, codes and constants for the line rasterizer
// no dependencies; imported by lr_step, line_rasterizer_core, lr_checker and tb_top
package lr_pkg;

  localparam int SCREEN_WIDTH = 240;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef struct packed {
    logic               busy;
    logic [7:0]         cur_row;
    logic [7:0]         cur_col;
    logic [7:0]         steps_left;
    logic signed [10:0] error_term;
    logic [7:0]         major_delta;
    logic [7:0]         minor_delta;
    logic               steep;
    logic               row_down;
    logic               col_down;
    logic [15:0]        line_color;
  } line_state_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] start_row;
    logic [7:0] start_col;
    logic [7:0] end_row;
    logic [7:0] end_col;
    logic [15:0] color;
  } line_word_t;

endpackage

@@ design/lr_step.sv @@
// lr_step: next line state and emitted pixel for one input word
// depends on lr_pkg
module lr_step
  import lr_pkg::*;
(
  input  line_state_t state,
  input  line_word_t  word,
  output line_state_t state_nxt,
  output logic        emit,
  output logic [15:0] offset
);

  logic [7:0]         adr;
  logic [7:0]         adc;
  logic               steep_new;
  logic [7:0]         major_new;
  logic [7:0]         minor_new;
  logic [9:0]         diff;
  logic [7:0]         row_stepped;
  logic [7:0]         col_stepped;
  logic [15:0]        row_prod;

  always_comb begin
    adr = (word.end_row >= word.start_row) ? (word.end_row - word.start_row)
                                           : (word.start_row - word.end_row);
    adc = (word.end_col >= word.start_col) ? (word.end_col - word.start_col)
                                           : (word.start_col - word.end_col);
    steep_new = adr > adc;
    major_new = steep_new ? adr : adc;
    minor_new = steep_new ? adc : adr;

    diff        = {2'b00, state.minor_delta} - {2'b00, state.major_delta};
    row_stepped = state.row_down ? (state.cur_row - 8'd1) : (state.cur_row + 8'd1);
    col_stepped = state.col_down ? (state.cur_col - 8'd1) : (state.cur_col + 8'd1);

    state_nxt = state;
    emit      = 1'b0;

    if (word.cmd == CMD_START) begin
      state_nxt.steep       = steep_new;
      state_nxt.row_down    = word.end_row < word.start_row;
      state_nxt.col_down    = word.end_col < word.start_col;
      state_nxt.major_delta = major_new;
      state_nxt.minor_delta = minor_new;
      state_nxt.error_term  = $signed({2'b00, minor_new, 1'b0} - {3'b000, major_new});
      state_nxt.steps_left  = major_new;
      state_nxt.cur_row     = word.start_row;
      state_nxt.cur_col     = word.start_col;
      state_nxt.line_color  = word.color;
      state_nxt.busy        = major_new != 8'd0;
      emit                  = 1'b1;
    end else if (state.busy) begin
      if (state.steep) begin
        state_nxt.cur_row = row_stepped;
      end else begin
        state_nxt.cur_col = col_stepped;
      end
      if (state.error_term > 11'sd0) begin
        if (state.steep) begin
          state_nxt.cur_col = col_stepped;
        end else begin
          state_nxt.cur_row = row_stepped;
        end
        state_nxt.error_term = state.error_term + $signed({diff, 1'b0});
      end else begin
        state_nxt.error_term = state.error_term +
                               $signed({2'b00, state.minor_delta, 1'b0});
      end
      state_nxt.steps_left = state.steps_left - 8'd1;
      state_nxt.busy       = state.steps_left != 8'd1;
      emit                 = 1'b1;
    end

    row_prod = 16'({8'b0, state_nxt.cur_row} * 16'(SCREEN_WIDTH));
    offset   = row_prod + {8'b0, state_nxt.cur_col};
  end

endmodule

@@ design/line_rasterizer_core.sv @@
// line_rasterizer_core: top level of the all-octant line rasterizer
// depends on lr_pkg and lr_step
//
// One word per cycle while in_ready is high. A start word (cmd 0) loads the
// endpoints and color and yields the first pixel; each advance word (cmd 1)
// yields the next pixel, with out_last set on the end endpoint. An advance
// while no line is active is taken and yields nothing. The pixel step, the
// decision-term update and the offset row*240+col are one combinational pass
// from the line state register into the output register, so with out_ready
// held high a word is taken every cycle; in_ready drops only while a pixel
// waits in the output register and out_ready is low.
module line_rasterizer_core
  import lr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_start_row,
  input  logic [7:0]  in_start_col,
  input  logic [7:0]  in_end_row,
  input  logic [7:0]  in_end_col,
  input  logic [15:0] in_color,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_row,
  output logic [7:0]  out_pixel_col,
  output logic [15:0] out_pixel_offset,
  output logic [15:0] out_pixel_color,
  output logic        out_last
);

  line_state_t state_r;
  line_state_t state_nxt;
  line_word_t  word;
  logic        emit;
  logic [15:0] offset;
  logic        in_fire;

  logic        out_valid_r;
  logic [7:0]  row_r;
  logic [7:0]  col_r;
  logic [15:0] offset_r;
  logic [15:0] color_r;
  logic        last_r;

  assign word = '{cmd: in_cmd, start_row: in_start_row, start_col: in_start_col,
                  end_row: in_end_row, end_col: in_end_col, color: in_color};

  lr_step u_step (
    .state     (state_r),
    .word      (word),
    .state_nxt (state_nxt),
    .emit      (emit),
    .offset    (offset)
  );

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= emit;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output word payload
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      row_r    <= state_nxt.cur_row;
      col_r    <= state_nxt.cur_col;
      offset_r <= offset;
      color_r  <= state_nxt.line_color;
      last_r   <= !state_nxt.busy;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_row    = row_r;
  assign out_pixel_col    = col_r;
  assign out_pixel_offset = offset_r;
  assign out_pixel_color  = color_r;
  assign out_last         = last_r;

endmodule

@@ design/lr_checker.sv @@
// lr_checker: port-level assertions for line_rasterizer_core, bound to it
// depends on lr_pkg and line_rasterizer_core
module lr_checker
  import lr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_cmd,
  input logic [7:0]  in_start_row,
  input logic [7:0]  in_start_col,
  input logic [15:0] in_color,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_pixel_row,
  input logic [7:0]  out_pixel_col,
  input logic [15:0] out_pixel_offset,
  input logic [15:0] out_pixel_color,
  input logic        out_last
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_row) &&
      $stable(out_pixel_col) && $stable(out_pixel_offset) &&
      $stable(out_pixel_color) && $stable(out_last))
    else $error("stalled output word changed");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("input stalled with output free");

  a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_START |=>
      out_valid && out_pixel_color == $past(in_color))
    else $error("start word gave no first pixel");

  a_start_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_cmd == CMD_START |=>
      out_pixel_row == $past(in_start_row) && out_pixel_col == $past(in_start_col))
    else $error("first pixel is not the start endpoint");

endmodule

bind line_rasterizer_core lr_checker u_lr_checker (.*);

@@ sim/tb_top.sv @@
// tb_top: self-checking testbench for line_rasterizer_core, with random gaps on both sides
// predicts every pixel from the start and advance words it sends and checks each output word
// depends on lr_pkg and line_rasterizer_core
module tb_top;
  import lr_pkg::*;

  localparam int WATCHDOG     = 2000;
  localparam int TAIL         = 20;
  localparam int RANDOM_WORDS = 500;

  typedef struct packed {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] offset;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_pixel_row;
  logic [7:0]  out_pixel_col;
  logic [15:0] out_pixel_offset;
  logic [15:0] out_pixel_color;
  logic        out_last;
  line_word_t  drv_word = '0;

  line_word_t  pending_words[$];
  pixel_t      pixel_q[$];
  line_state_t line_st;
  pixel_t      got_pixel;
  pixel_t      want_pixel;
  bit          in_fire;
  bit          out_fire;
  int          in_gap;
  int          out_stall;
  int          in_calm;
  int          out_calm;
  int          idle_cycles;
  int          mismatches;

  line_rasterizer_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (drv_word.cmd),
    .in_start_row     (drv_word.start_row),
    .in_start_col     (drv_word.start_col),
    .in_end_row       (drv_word.end_row),
    .in_end_col       (drv_word.end_col),
    .in_color         (drv_word.color),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_row    (out_pixel_row),
    .out_pixel_col    (out_pixel_col),
    .out_pixel_offset (out_pixel_offset),
    .out_pixel_color  (out_pixel_color),
    .out_last         (out_last)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap(inout int calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (roll < 3) calm = $urandom_range(20, 60);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [7:0] nudge(logic [7:0] v, logic down);
    return down ? v - 8'd1 : v + 8'd1;
  endfunction

  function automatic line_word_t rand_word();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(line_word_t)-1:0];
  endfunction

  function automatic void predict_pixel(line_word_t w);
    logic [7:0] adr;
    logic [7:0] adc;
    int         e;
    if (w.cmd == CMD_START) begin
      adr = (w.end_row >= w.start_row) ? w.end_row - w.start_row : w.start_row - w.end_row;
      adc = (w.end_col >= w.start_col) ? w.end_col - w.start_col : w.start_col - w.end_col;
      line_st.steep = adr > adc;
      line_st.row_down = w.end_row < w.start_row;
      line_st.col_down = w.end_col < w.start_col;
      line_st.major_delta = line_st.steep ? adr : adc;
      line_st.minor_delta = line_st.steep ? adc : adr;
      e = 2 * int'(line_st.minor_delta) - int'(line_st.major_delta);
      line_st.error_term = e[10:0];
      line_st.steps_left = line_st.major_delta;
      line_st.cur_row = w.start_row;
      line_st.cur_col = w.start_col;
      line_st.line_color = w.color;
      line_st.busy = line_st.steps_left != 8'd0;
    end else if (!line_st.busy) begin
      return;
    end else begin
      if (line_st.steep) line_st.cur_row = nudge(line_st.cur_row, line_st.row_down);
      else line_st.cur_col = nudge(line_st.cur_col, line_st.col_down);
      e = $signed(line_st.error_term);
      if (e > 0) begin
        if (line_st.steep) line_st.cur_col = nudge(line_st.cur_col, line_st.col_down);
        else line_st.cur_row = nudge(line_st.cur_row, line_st.row_down);
        e = e + 2 * (int'(line_st.minor_delta) - int'(line_st.major_delta));
      end else begin
        e = e + 2 * int'(line_st.minor_delta);
      end
      line_st.error_term = e[10:0];
      line_st.steps_left = line_st.steps_left - 8'd1;
      line_st.busy = line_st.steps_left != 8'd0;
    end
    pixel_q.push_back('{
      row:    line_st.cur_row,
      col:    line_st.cur_col,
      offset: 16'(int'(line_st.cur_row) * SCREEN_WIDTH + int'(line_st.cur_col)),
      color:  line_st.line_color,
      last:   !line_st.busy
    });
  endfunction

  function automatic void queue_line(logic [7:0] r0, logic [7:0] c0, logic [7:0] r1,
                                     logic [7:0] c1, logic [15:0] color, int advances);
    line_word_t w;
    w = '{cmd: CMD_START, start_row: r0, start_col: c0, end_row: r1, end_col: c1,
          color: color};
    pending_words.push_back(w);
    repeat (advances) begin
      w = rand_word();
      w.cmd = CMD_ADVANCE;
      pending_words.push_back(w);
    end
  endfunction

  function automatic void queue_random_line();
    int kind;
    int r0;
    int c0;
    int r1;
    int c1;
    int major;
    int adv;
    kind = $urandom_range(0, 99);
    r0 = $urandom_range(0, 159);
    c0 = $urandom_range(0, 239);
    if (kind < 85) begin
      r1 = r0 + int'($urandom_range(0, 16)) - 8;
      c1 = c0 + int'($urandom_range(0, 16)) - 8;
      if (r1 < 0) r1 = 0;
      if (r1 > 159) r1 = 159;
      if (c1 < 0) c1 = 0;
      if (c1 > 239) c1 = 239;
    end else if (kind < 95) begin
      r1 = $urandom_range(0, 159);
      c1 = $urandom_range(0, 239);
    end else begin
      r0 = $urandom_range(0, 255);
      c0 = $urandom_range(0, 255);
      r1 = $urandom_range(0, 255);
      c1 = $urandom_range(0, 255);
    end
    major = (r1 > r0) ? r1 - r0 : r0 - r1;
    if (((c1 > c0) ? c1 - c0 : c0 - c1) > major) major = (c1 > c0) ? c1 - c0 : c0 - c1;
    kind = $urandom_range(0, 99);
    if (kind < 80) adv = major;
    else if (kind < 90) adv = $urandom_range(0, major);
    else adv = major + int'($urandom_range(1, 3));
    queue_line(r0[7:0], c0[7:0], r1[7:0], c1[7:0], 16'($urandom), adv);
  endfunction

  // scoreboard and predictor, sampled at the rising edge
  always @(posedge clk) begin
    in_fire = rst_n && in_valid && in_ready;
    out_fire = rst_n && out_valid && out_ready;
    if (out_fire) begin
      got_pixel = '{row: out_pixel_row, col: out_pixel_col, offset: out_pixel_offset,
                    color: out_pixel_color, last: out_last};
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel word %p", got_pixel);
      end else begin
        want_pixel = pixel_q.pop_front();
        if (got_pixel !== want_pixel) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected %p, got %p", want_pixel, got_pixel);
        end
      end
    end
    if (in_fire) predict_pixel(drv_word);
    idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
  end

  // input driver
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_fire)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() != 0) begin
        drv_word <= pending_words.pop_front();
        in_valid <= 1'b1;
        in_gap = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output backpressure
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) out_stall = pick_gap(out_calm);
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int target;
    line_st = '0;
    // single point, then an advance with no line active
    queue_line(8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 1);
    queue_line(8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF, 0);
    // full diagonal cut short by a new start
    queue_line(8'd0, 8'd0, 8'd159, 8'd239, 16'hA5A5, 2);
    queue_line(8'd159, 8'd239, 8'd0, 8'd0, 16'h5A5A, 1);
    // steep up-left, run past its end
    queue_line(8'd80, 8'd120, 8'd77, 8'd118, 16'h1234, 4);
    queue_line(8'd10, 8'd10, 8'd11, 8'd14, 16'hFEDC, 4);
    // off-screen endpoints
    queue_line(8'd0, 8'd255, 8'd255, 8'd0, 16'h8001, 1);
    target = pending_words.size() + RANDOM_WORDS;
    while (pending_words.size() < target) begin
      if ($urandom_range(0, 19) == 0) pending_words.push_back(rand_word());
      else queue_random_line();
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while ((pending_words.size() != 0 || in_valid || pixel_q.size() != 0) &&
           idle_cycles < WATCHDOG)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG) begin
      $display("tb: failure");
    end else begin
      repeat (TAIL) @(posedge clk);
      if (mismatches == 0 && pixel_q.size() == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
    end
    $finish;
  end

endmodule
